// ===== hdl/ptfq_pkg.sv =====
// Package: shared types and constants for the priority transmit frame slot queue.
`timescale 1ns / 1ps

package ptfq_pkg;

  localparam int SLOTS_DEF      = 3;
  localparam int SLOT_WORDS_DEF = 256;
  localparam int AGE_W          = 16;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_REJECT  = 2'd1,
    ST_SENT    = 2'd2,
    ST_NOTHING = 2'd3
  } status_t;

  typedef enum logic {
    ACT_OFFER    = 1'b0,
    ACT_TRANSMIT = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  frame_word;
    logic [1:0]  slot_priority;
    logic        last_word;
  } ptfq_in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  tx_octet;
    logic        frame_end;
    logic [1:0]  free_slots;
    logic        idle;
  } ptfq_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ptfq_cmd_t;

endpackage

// ===== hdl/ptfq_ctrl.sv =====
// Controller: sequences capture, execute and result strobe for each word.
`timescale 1ns / 1ps

module ptfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output ptfq_pkg::ptfq_cmd_t cmd
);
  import ptfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;

  always_comb begin
    cmd.load = start && !busy;
    cmd.exec = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        S_RESP: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ptfq_dp.sv =====
// Datapath: slot table, admission and selection logic, frame octet memory.
`timescale 1ns / 1ps

module ptfq_dp #(
  parameter int SLOTS      = ptfq_pkg::SLOTS_DEF,
  parameter int SLOT_WORDS = ptfq_pkg::SLOT_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ptfq_pkg::ptfq_cmd_t cmd,
  input  ptfq_pkg::ptfq_in_t  req,
  output ptfq_pkg::ptfq_out_t rsp
);
  import ptfq_pkg::*;

  localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW        = $clog2(SLOT_WORDS);
  localparam int LW        = $clog2(SLOT_WORDS + 1);
  localparam int AW        = SW + PW;
  localparam int MEM_DEPTH = SLOTS << PW;

  typedef enum logic [1:0] {
    PH_FREE = 2'd0,
    PH_FILL = 2'd1,
    PH_PEND = 2'd2,
    PH_ACT  = 2'd3
  } phase_t;

  // slot table
  phase_t           phase      [SLOTS];
  logic             prio       [SLOTS];
  logic [LW-1:0]    length     [SLOTS];
  logic [LW-1:0]    position   [SLOTS];
  logic [AGE_W-1:0] age        [SLOTS];
  phase_t           phase_next    [SLOTS];
  logic             prio_next     [SLOTS];
  logic [LW-1:0]    length_next   [SLOTS];
  logic [LW-1:0]    position_next [SLOTS];
  logic [AGE_W-1:0] age_next      [SLOTS];

  logic             fill_valid, fill_valid_next;
  logic [SW-1:0]    fill_idx, fill_idx_next;
  logic             act_valid, act_valid_next;
  logic [SW-1:0]    act_idx, act_idx_next;
  logic             dropping, dropping_next;
  logic [AGE_W-1:0] submit_cnt, submit_cnt_next;

  ptfq_in_t         in_q;
  ptfq_out_t        res;
  ptfq_out_t        res_next;

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rdata;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;

  // occupancy and oldest-pending search over the current table
  logic [1:0]       n_free;
  logic             any_free;
  logic [SW-1:0]    first_free;
  logic             hi_valid, lo_valid;
  logic [SW-1:0]    hi_idx, lo_idx;

  always_comb begin
    logic [AGE_W-1:0] dh;
    logic [AGE_W-1:0] dl;
    n_free     = '0;
    any_free   = 1'b0;
    first_free = '0;
    hi_valid   = 1'b0;
    lo_valid   = 1'b0;
    hi_idx     = '0;
    lo_idx     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      dh = age[i] - age[hi_idx];
      dl = age[i] - age[lo_idx];
      if (phase[i] == PH_FREE) begin
        n_free = n_free + 2'd1;
        if (!any_free) begin
          any_free   = 1'b1;
          first_free = SW'(i);
        end
      end
      if (phase[i] == PH_PEND && prio[i] && (!hi_valid || dh[AGE_W-1])) begin
        hi_valid = 1'b1;
        hi_idx   = SW'(i);
      end
      if (phase[i] == PH_PEND && !prio[i] && (!lo_valid || dl[AGE_W-1])) begin
        lo_valid = 1'b1;
        lo_idx   = SW'(i);
      end
    end
  end

  // one step of the queue
  always_comb begin
    logic          go;
    logic          admit;
    logic          ok;
    logic [SW-1:0] sel;
    logic [LW-1:0] cur_len;
    logic [LW-1:0] cur_pos;
    logic [LW-1:0] nxt_pos;
    logic [1:0]    nf;
    logic          pend;
    phase_next      = phase;
    prio_next       = prio;
    length_next     = length;
    position_next   = position;
    age_next        = age;
    fill_valid_next = fill_valid;
    fill_idx_next   = fill_idx;
    act_valid_next  = act_valid;
    act_idx_next    = act_idx;
    dropping_next   = dropping;
    submit_cnt_next = submit_cnt;
    we              = 1'b0;
    re              = 1'b0;
    waddr           = '0;
    raddr           = '0;
    go              = 1'b1;
    admit           = 1'b0;
    ok              = 1'b0;
    sel             = fill_idx;
    cur_len         = '0;
    cur_pos         = '0;
    nxt_pos         = '0;
    nf              = '0;
    pend            = 1'b0;
    res_next        = '0;
    res_next.status = ST_STORED;

    if (in_q.action == ACT_OFFER) begin
      if (dropping) begin
        if (in_q.last_word) begin
          dropping_next = 1'b0;
        end
        res_next.status = ST_REJECT;
      end else begin
        if (!fill_valid) begin
          if (in_q.slot_priority == 2'd1) begin
            ok = (n_free >= 2'd1);
          end else begin
            ok = (in_q.slot_priority == 2'd0) && (n_free >= 2'd2);
          end
          if (!ok || !any_free) begin
            dropping_next   = !in_q.last_word;
            res_next.status = ST_REJECT;
            go              = 1'b0;
          end else begin
            admit = 1'b1;
            sel   = first_free;
          end
        end
        if (go) begin
          cur_len = admit ? '0 : length[sel];
          if (cur_len >= LW'(SLOT_WORDS)) begin
            // overlong: free the slot, drop the rest
            phase_next[sel] = PH_FREE;
            fill_valid_next = 1'b0;
            dropping_next   = !in_q.last_word;
            res_next.status = ST_REJECT;
          end else begin
            we                = 1'b1;
            waddr             = {sel, cur_len[PW-1:0]};
            length_next[sel]  = cur_len + LW'(1);
            phase_next[sel]   = in_q.last_word ? PH_PEND : PH_FILL;
            fill_valid_next   = !in_q.last_word;
            fill_idx_next     = sel;
            if (admit) begin
              prio_next[sel]     = in_q.slot_priority[0];
              position_next[sel] = '0;
              age_next[sel]      = submit_cnt;
              submit_cnt_next    = submit_cnt + AGE_W'(1);
            end
          end
        end
      end
    end else begin
      sel = act_idx;
      if (!act_valid) begin
        if (hi_valid) begin
          sel = hi_idx;
        end else if (lo_valid) begin
          sel = lo_idx;
        end else begin
          go = 1'b0;
        end
      end
      if (!go) begin
        act_valid_next  = 1'b0;
        res_next.status = ST_NOTHING;
      end else begin
        cur_pos            = act_valid ? position[sel] : '0;
        nxt_pos            = cur_pos + LW'(1);
        re                 = 1'b1;
        raddr              = {sel, cur_pos[PW-1:0]};
        position_next[sel] = nxt_pos;
        res_next.status    = ST_SENT;
        if (nxt_pos >= length[sel]) begin
          phase_next[sel]    = PH_FREE;
          act_valid_next     = 1'b0;
          res_next.frame_end = 1'b1;
        end else begin
          phase_next[sel] = PH_ACT;
          act_valid_next  = 1'b1;
          act_idx_next    = sel;
        end
      end
    end

    for (int i = 0; i < SLOTS; i++) begin
      if (phase_next[i] == PH_FREE) begin
        nf = nf + 2'd1;
      end
      if (phase_next[i] == PH_PEND) begin
        pend = 1'b1;
      end
    end
    res_next.free_slots = nf;
    res_next.idle       = !act_valid_next && !pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase[i]    <= PH_FREE;
        prio[i]     <= 1'b0;
        length[i]   <= '0;
        position[i] <= '0;
        age[i]      <= '0;
      end
      fill_valid <= 1'b0;
      fill_idx   <= '0;
      act_valid  <= 1'b0;
      act_idx    <= '0;
      dropping   <= 1'b0;
      submit_cnt <= '0;
      res        <= '0;
    end else if (cmd.exec) begin
      phase      <= phase_next;
      prio       <= prio_next;
      length     <= length_next;
      position   <= position_next;
      age        <= age_next;
      fill_valid <= fill_valid_next;
      fill_idx   <= fill_idx_next;
      act_valid  <= act_valid_next;
      act_idx    <= act_idx_next;
      dropping   <= dropping_next;
      submit_cnt <= submit_cnt_next;
      res        <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= req;
    end
  end

  // frame octet memory, one port used per word
  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= in_q.frame_word;
    end
    if (cmd.exec && re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    rsp          = res;
    rsp.tx_octet = (res.status == ST_SENT) ? rdata : 8'd0;
  end

endmodule

// ===== hdl/priority_tx_frame_slot_queue_unit.sv =====
// Top level: two-priority transmit frame queue with a reserved slot.
`timescale 1ns / 1ps

// For each word the controller first updates the slot table and accesses the octet
// memory, whose read data is registered, and then shows the result with done high.
// busy is high only during the update, so a new word may be started while done is
// shown. done is high for exactly one cycle and the result cannot be held off. The
// octet memory needs no clearing after reset.
module priority_tx_frame_slot_queue_unit #(
  parameter int SLOTS      = ptfq_pkg::SLOTS_DEF,
  parameter int SLOT_WORDS = ptfq_pkg::SLOT_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ptfq_pkg::ptfq_in_t  req,
  output logic                done,
  output ptfq_pkg::ptfq_out_t rsp
);
  import ptfq_pkg::*;

  ptfq_cmd_t cmd;

  ptfq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ptfq_dp #(
    .SLOTS      (SLOTS),
    .SLOT_WORDS (SLOT_WORDS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== sim/tb_priority_tx_frame_slot_queue_unit.sv =====
// Testbench: directed and random frame traffic against a predictor of the slot queue.
`timescale 1ns / 1ps

module tb_priority_tx_frame_slot_queue_unit;
  import ptfq_pkg::*;

  localparam int NSLOT   = SLOTS_DEF;
  localparam int DEPTH   = SLOT_WORDS_DEF;
  localparam int NO_SLOT = 3;

  typedef enum logic [1:0] {
    SL_FREE = 2'd0,
    SL_FILL = 2'd1,
    SL_PEND = 2'd2,
    SL_ACT  = 2'd3
  } slot_state_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  ptfq_in_t  req;
  logic      done;
  ptfq_out_t rsp;

  priority_tx_frame_slot_queue_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // predictor state
  slot_state_t sl_state[NSLOT];
  logic        sl_high[NSLOT];
  int          sl_len[NSLOT];
  int          sl_pos[NSLOT];
  logic [15:0] sl_age[NSLOT];
  logic [7:0]  sl_mem[NSLOT][DEPTH];
  int          active_idx;
  int          fill_idx;
  bit          discarding;
  logic [15:0] admit_count;

  ptfq_out_t awaited_rsp[$];
  int        mismatch_count = 0;
  int        words_sent = 0;
  int        steady_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int empty_slot_total();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++)
      if (sl_state[i] == SL_FREE) n++;
    return n;
  endfunction

  function automatic int oldest_waiting(logic hi);
    int          best;
    logic [15:0] diff;
    best = NO_SLOT;
    for (int i = 0; i < NSLOT; i++) begin
      if (sl_state[i] == SL_PEND && sl_high[i] == hi) begin
        if (best == NO_SLOT) begin
          best = i;
        end else begin
          diff = sl_age[i] - sl_age[best];
          if (diff[15]) best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic status_t store_word(logic [7:0] d, logic [1:0] p, logic lst);
    int s;
    int nfree;
    bit ok;
    if (discarding) begin
      if (lst) discarding = 1'b0;
      return ST_REJECT;
    end
    if (fill_idx == NO_SLOT) begin
      nfree = empty_slot_total();
      ok = (p == 2'd1) ? (nfree >= 1) : (p == 2'd0 && nfree >= 2);
      if (!ok) begin
        discarding = !lst;
        return ST_REJECT;
      end
      s = NO_SLOT;
      for (int i = NSLOT - 1; i >= 0; i--)
        if (sl_state[i] == SL_FREE) s = i;
      sl_state[s] = SL_FILL;
      sl_high[s]  = p[0];
      sl_len[s]   = 0;
      sl_pos[s]   = 0;
      sl_age[s]   = admit_count;
      admit_count = admit_count + 16'd1;
      fill_idx    = s;
    end
    s = fill_idx;
    // overlong: slot given back, rest of frame discarded
    if (sl_len[s] >= DEPTH) begin
      sl_state[s] = SL_FREE;
      fill_idx    = NO_SLOT;
      discarding  = !lst;
      return ST_REJECT;
    end
    sl_mem[s][sl_len[s]] = d;
    sl_len[s]++;
    if (lst) begin
      sl_state[s] = SL_PEND;
      fill_idx    = NO_SLOT;
    end
    return ST_STORED;
  endfunction

  function automatic status_t send_octet(output logic [7:0] o, output logic e);
    int s;
    o = 8'd0;
    e = 1'b0;
    s = active_idx;
    if (s == NO_SLOT) begin
      s = oldest_waiting(1'b1);
      if (s == NO_SLOT) s = oldest_waiting(1'b0);
      if (s == NO_SLOT) return ST_NOTHING;
      sl_pos[s]   = 0;
      sl_state[s] = SL_ACT;
      active_idx  = s;
    end
    o = sl_mem[s][sl_pos[s]];
    sl_pos[s]++;
    if (sl_pos[s] >= sl_len[s]) begin
      sl_state[s] = SL_FREE;
      active_idx  = NO_SLOT;
      e           = 1'b1;
    end
    return ST_SENT;
  endfunction

  function automatic ptfq_out_t queue_step(ptfq_in_t w);
    ptfq_out_t  r;
    logic [7:0] o;
    logic       e;
    bit         waiting;
    r = '0;
    if (w.action == ACT_OFFER) begin
      r.status = store_word(w.frame_word, w.slot_priority, w.last_word);
    end else begin
      r.status    = send_octet(o, e);
      r.tx_octet  = o;
      r.frame_end = e;
    end
    waiting = 1'b0;
    for (int i = 0; i < NSLOT; i++)
      if (sl_state[i] == SL_PEND) waiting = 1'b1;
    r.free_slots = 2'(empty_slot_total());
    r.idle       = (active_idx == NO_SLOT) && !waiting;
    return r;
  endfunction

  task automatic clear_queue_model();
    for (int i = 0; i < NSLOT; i++) begin
      sl_state[i] = SL_FREE;
      sl_high[i]  = 1'b0;
      sl_len[i]   = 0;
      sl_pos[i]   = 0;
      sl_age[i]   = 16'd0;
    end
    active_idx  = NO_SLOT;
    fill_idx    = NO_SLOT;
    discarding  = 1'b0;
    admit_count = 16'd0;
  endtask

  // start is left high on return; idle_gap lowers it if no word follows at once
  task automatic issue_word(ptfq_in_t w);
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
    awaited_rsp.push_back(queue_step(w));
    words_sent++;
  endtask

  task automatic idle_gap();
    int n;
    int r;
    n = 0;
    r = $urandom_range(0, 99);
    if (steady_left > 0) steady_left--;
    else if (r < 2) steady_left = $urandom_range(20, 60);
    else if (r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 8);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer_item(logic [7:0] d, logic [1:0] p, logic lst);
    ptfq_in_t w;
    w.action        = ACT_OFFER;
    w.frame_word    = d;
    w.slot_priority = p;
    w.last_word     = lst;
    issue_word(w);
    idle_gap();
  endtask

  task automatic tx_chance();
    ptfq_in_t w;
    w.action        = ACT_TRANSMIT;
    w.frame_word    = 8'($urandom);
    w.slot_priority = 2'($urandom);
    w.last_word     = 1'($urandom);
    issue_word(w);
    idle_gap();
  endtask

  task automatic send_frame(int len, logic [1:0] prio, bit close, int tx_pct);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < tx_pct) tx_chance();
      offer_item(8'($urandom), (k == 0) ? prio : 2'($urandom), close && (k == len - 1));
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    tx_chance();
  endtask

  task automatic test_bad_priority();
    offer_item(8'h00, 2'd2, 1'b1);
    offer_item(8'hFF, 2'd3, 1'b0);
    offer_item(8'h11, 2'd0, 1'b0);
    offer_item(8'h22, 2'd1, 1'b1);
  endtask

  task automatic test_admission_rules();
    offer_item(8'h00, 2'd0, 1'b0);
    tx_chance();                    // frame still filling: nothing to send
    offer_item(8'hFF, 2'd3, 1'b1);  // priority ignored after the first word
    offer_item(8'h5A, 2'd0, 1'b1);
    offer_item(8'h77, 2'd0, 1'b1);  // normal frame, reserved slot only
    offer_item(8'hA5, 2'd1, 1'b0);
    offer_item(8'h3C, 2'd2, 1'b1);
    offer_item(8'h99, 2'd1, 1'b1);  // no slot left
  endtask

  task automatic test_priority_order();
    repeat (6) tx_chance();
  endtask

  task automatic test_long_frames();
    send_frame(DEPTH + 1, 2'd1, 1'b0, 0);
    offer_item(8'($urandom), 2'($urandom), 1'b0);
    offer_item(8'($urandom), 2'($urandom), 1'b1);
    send_frame(DEPTH, 2'd0, 1'b1, 0);
    repeat (DEPTH + 1) tx_chance();
  endtask

  task automatic test_random_traffic(int upto);
    int         r;
    int         len;
    logic [1:0] prio;
    ptfq_in_t   w;
    while (words_sent < upto) begin
      r    = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      prio = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      if (r < 50) begin
        send_frame(len, prio, 1'b1, 30);
      end else if (r < 88) begin
        repeat ($urandom_range(1, 8)) tx_chance();
      end else if (r < 94) begin
        send_frame(len, prio, 1'b0, 30);  // left open, later words join it
      end else begin
        w = ptfq_in_t'(12'($urandom));
        issue_word(w);
        idle_gap();
      end
    end
  endtask

  task automatic test_drain_pause();
    drain_results();
    repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  always @(posedge clk) begin
    ptfq_out_t want;
    if (!rst && done) begin
      if (awaited_rsp.size() == 0) begin
        $error("result with no word outstanding: %h", rsp);
        mismatch_count++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.tx_octet !== want.tx_octet) begin
          $error("tx_octet: expected %h, got %h", want.tx_octet, rsp.tx_octet);
          mismatch_count++;
        end
        if (rsp.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, rsp.frame_end);
          mismatch_count++;
        end
        if (rsp.free_slots !== want.free_slots) begin
          $error("free_slots: expected %0d, got %0d", want.free_slots, rsp.free_slots);
          mismatch_count++;
        end
        if (rsp.idle !== want.idle) begin
          $error("idle: expected %b, got %b", want.idle, rsp.idle);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    clear_queue_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_bad_priority();
    test_admission_rules();
    test_priority_order();
    test_long_frames();
    test_random_traffic(1300);
    test_drain_pause();
    test_random_traffic(1950);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
